### hw/rtl/nvr_pkg.sv
// ============================================================================
// nvr_pkg - shared constants and types for the null vector block
// Widths, Q16.16 constants and the controller/datapath handshake structs.
// ============================================================================
package nvr_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MAT_DEPTH   = MAX_COLUMNS * (MAX_COLUMNS - 1);
    localparam int MAT_AW      = $clog2(MAT_DEPTH);
    localparam int IDX_W       = $clog2(MAX_COLUMNS);
    localparam int COL_W       = 6;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q16 = -32'sh0001_0000;

    // vector store write sources driven by the controller
    localparam logic [1:0] VW_NONE = 2'd0;
    localparam logic [1:0] VW_INIT = 2'd1;
    localparam logic [1:0] VW_ONE  = 2'd2;

    typedef struct packed {
        logic              mat_we;
        logic [MAT_AW-1:0] mat_waddr;
        logic [MAT_AW-1:0] mat_raddr;
        logic [IDX_W-1:0]  vec_raddr;
        logic [1:0]        vec_wsel;
        logic [IDX_W-1:0]  vec_waddr;
        logic              cap_first;
        logic              cap_diag;
        logic              row_clr;
        logic              scan;
        logic [IDX_W-1:0]  scan_k;
        logic              fr;
        logic [IDX_W-1:0]  fr_idx;
        logic              neg;
        logic              rnd;
        logic              out_load;
        logic              out_last;
        logic              out_err;
    } t_cmd;

    typedef struct packed {
        logic first_zero;
        logic diag_one;
        logic out_acc;
    } t_stat;

endpackage

### hw/rtl/nvr_dpath.sv
// ============================================================================
// nvr_dpath - matrix/vector stores, multiply-accumulate and result register
// Executes controller commands: loads entries, scans rows for the pivot,
// accumulates products with saturation, rounds and writes vector elements.
// ============================================================================
module nvr_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nvr_pkg::t_cmd                i_cmd,
    output nvr_pkg::t_stat               o_stat,
    input  logic [nvr_pkg::DATA_W-1:0]   i_in_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [nvr_pkg::DATA_W-1:0]   o_out_data,
    output logic                         o_out_last,
    output logic [1:0]                   o_out_user
);

    localparam int DW = nvr_pkg::DATA_W;
    localparam int PW = nvr_pkg::PROD_W;
    localparam logic signed [PW-1:0] ACC_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] ACC_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] Q_MIN   = {1'b1, {(DW-1){1'b0}}};

    logic [DW-1:0] r_mat [0:nvr_pkg::MAT_DEPTH-1];
    logic [DW:0]   r_vec [0:nvr_pkg::MAX_COLUMNS-1];

    logic signed [DW-1:0]      r_mat_rd;
    logic [DW:0]               r_vec_rd;
    logic                      r_s1_valid;
    logic [nvr_pkg::IDX_W-1:0] r_s1_k;
    logic                      r_found;
    logic [nvr_pkg::IDX_W-1:0] r_lead;
    logic signed [PW-1:0]      r_prod;
    logic                      r_p_valid;
    logic signed [PW-1:0]      r_acc;
    logic signed [PW-1:0]      r_neg;
    logic                      r_fr_valid;
    logic [nvr_pkg::IDX_W-1:0] r_fr_idx;
    logic                      r_first_zero;
    logic                      r_diag_one;
    logic                      r_o_valid;
    logic [DW-1:0]             r_o_data;
    logic                      r_o_last;
    logic                      r_o_status;
    logic                      r_o_sat;

    logic signed [DW-1:0]      w_va;
    logic signed [PW-1:0]      w_prod;
    logic signed [PW:0]        w_sum;
    logic signed [PW-1:0]      w_acc_add;
    logic signed [PW:0]        w_t;
    logic [PW-16:0]            w_q;
    logic                      w_clip;
    logic [DW-1:0]             w_qval;
    logic                      w_vwe;
    logic [nvr_pkg::IDX_W-1:0] w_vwaddr;
    logic [DW:0]               w_vwdata;
    logic                      w_out_acc;

    assign w_va   = r_vec_rd[DW-1:0];
    assign w_prod = w_va * r_mat_rd;

    // saturating accumulate
    assign w_sum = {r_acc[PW-1], r_acc} + {r_prod[PW-1], r_prod};
    always_comb begin
        if (w_sum[PW] != w_sum[PW-1]) begin
            w_acc_add = w_sum[PW] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_add = w_sum[PW-1:0];
        end
    end

    // round half up to Q16.16, then clip to 32 bits
    assign w_t = {r_neg[PW-1], r_neg} + (PW+1)'(32768);
    assign w_q = w_t[PW:16];
    assign w_clip = !((&w_q[PW-16:DW-1]) || !(|w_q[PW-16:DW-1]));
    always_comb begin
        if (w_clip) begin
            w_qval = w_q[PW-16] ? Q_MIN : Q_MAX;
        end else begin
            w_qval = w_q[DW-1:0];
        end
    end

    always_comb begin
        w_vwe    = 1'b0;
        w_vwaddr = i_cmd.vec_waddr;
        w_vwdata = '0;
        if (r_fr_valid) begin
            w_vwe    = 1'b1;
            w_vwaddr = r_fr_idx;
            if (r_mat_rd == Q_MIN) begin
                w_vwdata = {1'b1, Q_MAX};
            end else begin
                w_vwdata = {1'b0, -r_mat_rd};
            end
        end else if (i_cmd.vec_wsel == nvr_pkg::VW_INIT) begin
            w_vwe    = 1'b1;
            w_vwdata = {1'b0, i_cmd.vec_waddr[0] ? nvr_pkg::ONE_Q16 : nvr_pkg::NEG_ONE_Q16};
        end else if (i_cmd.vec_wsel == nvr_pkg::VW_ONE) begin
            w_vwe    = 1'b1;
            w_vwdata = {1'b0, nvr_pkg::ONE_Q16};
        end else if (i_cmd.rnd && r_found) begin
            w_vwe    = 1'b1;
            w_vwaddr = r_lead;
            w_vwdata = {w_clip, w_qval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) begin
            r_mat[i_cmd.mat_waddr] <= i_in_data;
        end
        r_mat_rd <= r_mat[i_cmd.mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vec[w_vwaddr] <= w_vwdata;
        end
        r_vec_rd <= r_vec[i_cmd.vec_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_k   <= i_cmd.scan_k;
        r_prod   <= w_prod;
        r_fr_idx <= i_cmd.fr_idx;
        if (i_cmd.neg) begin
            r_neg <= (r_acc == ACC_MIN) ? ACC_MAX : -r_acc;
        end
        if (r_s1_valid && !r_found && (r_mat_rd == nvr_pkg::ONE_Q16)) begin
            r_lead <= r_s1_k;
        end
        if (i_cmd.out_err) begin
            r_o_data   <= '0;
            r_o_last   <= 1'b1;
            r_o_status <= 1'b1;
            r_o_sat    <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_data   <= r_vec_rd[DW-1:0];
            r_o_last   <= i_cmd.out_last;
            r_o_status <= 1'b0;
            r_o_sat    <= r_vec_rd[DW];
        end
    end

    assign w_out_acc = r_o_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_p_valid    <= 1'b0;
            r_acc        <= '0;
            r_fr_valid   <= 1'b0;
            r_first_zero <= 1'b0;
            r_diag_one   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.scan;
            r_p_valid  <= r_s1_valid && r_found;
            r_fr_valid <= i_cmd.fr;
            if (i_cmd.row_clr) begin
                r_found <= 1'b0;
                r_acc   <= '0;
            end else begin
                if (r_s1_valid && (r_mat_rd == nvr_pkg::ONE_Q16)) begin
                    r_found <= 1'b1;
                end
                if (r_p_valid) begin
                    r_acc <= w_acc_add;
                end
            end
            if (i_cmd.mat_we && i_cmd.cap_first) begin
                r_first_zero <= (i_in_data == '0);
            end
            if (i_cmd.mat_we && i_cmd.cap_diag) begin
                r_diag_one <= (i_in_data == nvr_pkg::ONE_Q16);
            end
            if (i_cmd.out_err || i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat.first_zero = r_first_zero;
    assign o_stat.diag_one   = r_diag_one;
    assign o_stat.out_acc    = w_out_acc;

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_last  = r_o_last;
    assign o_out_user  = {r_o_sat, r_o_status};

endmodule

### hw/rtl/nvr_ctrl.sv
// ============================================================================
// nvr_ctrl - sequencer for load, back-substitution and result readout
// Holds column count, entry counter and row/column loop indexes.
// ============================================================================
module nvr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nvr_pkg::COL_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output nvr_pkg::t_cmd               o_cmd,
    input  nvr_pkg::t_stat              i_stat
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_INIT     = 4'd2;
    localparam logic [3:0] S_ROW      = 4'd3;
    localparam logic [3:0] S_DRAIN1   = 4'd4;
    localparam logic [3:0] S_DRAIN2   = 4'd5;
    localparam logic [3:0] S_NEG      = 4'd6;
    localparam logic [3:0] S_RND      = 4'd7;
    localparam logic [3:0] S_FR       = 4'd8;
    localparam logic [3:0] S_FR_DRAIN = 4'd9;
    localparam logic [3:0] S_FR_ONE   = 4'd10;
    localparam logic [3:0] S_OUT_RD   = 4'd11;
    localparam logic [3:0] S_OUT_LD   = 4'd12;
    localparam logic [3:0] S_OUT_WAIT = 4'd13;
    localparam logic [3:0] S_ERR_WAIT = 4'd14;

    localparam int AW = nvr_pkg::MAT_AW;
    localparam int IW = nvr_pkg::IDX_W;
    localparam int CW = nvr_pkg::COL_W;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [IW-1:0] r_n_m1, n_n_m1;
    logic [IW-1:0] r_n_m2, n_n_m2;
    logic [AW-1:0] r_tot_m1, n_tot_m1;
    logic [AW-1:0] r_tot_m2, n_tot_m2;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] r_i, n_i;
    logic [AW-1:0] r_base, n_base;

    logic [CW-1:0]   w_nc;
    logic [2*CW-1:0] w_total;
    logic            w_acc;

    always_comb begin
        if (i_cfg_wdata < CW'(2)) begin
            w_nc = CW'(2);
        end else if (i_cfg_wdata > CW'(nvr_pkg::MAX_COLUMNS)) begin
            w_nc = CW'(nvr_pkg::MAX_COLUMNS);
        end else begin
            w_nc = i_cfg_wdata;
        end
    end
    assign w_total = w_nc * (w_nc - CW'(1));

    assign o_in_ready = (r_state == S_LOAD);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_n_m1   = r_n_m1;
        n_n_m2   = r_n_m2;
        n_tot_m1 = r_tot_m1;
        n_tot_m2 = r_tot_m2;
        n_k      = r_k;
        n_i      = r_i;
        n_base   = r_base;
        o_cmd           = '0;
        o_cmd.mat_waddr = r_cnt;
        o_cmd.vec_wsel  = nvr_pkg::VW_NONE;
        o_cmd.vec_waddr = r_k;
        o_cmd.vec_raddr = r_k;
        o_cmd.scan_k    = r_k;
        o_cmd.fr_idx    = r_i;
        o_cmd.mat_raddr = r_base + AW'(r_k);

        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    o_cmd.mat_we    = 1'b1;
                    o_cmd.cap_first = (r_cnt == '0);
                    o_cmd.cap_diag  = (r_cnt == r_tot_m2);
                    if (r_cnt == r_tot_m1) begin
                        n_cnt   = '0;
                        n_state = S_DECIDE;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end
            end
            S_DECIDE: begin
                n_k    = '0;
                n_i    = '0;
                n_base = '0;
                if (i_stat.first_zero) begin
                    o_cmd.out_err = 1'b1;
                    n_state = S_ERR_WAIT;
                end else if (i_stat.diag_one) begin
                    n_state = S_FR;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.vec_wsel = nvr_pkg::VW_INIT;
                if (r_k == r_n_m1) begin
                    n_k     = '0;
                    n_state = S_ROW;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_ROW: begin
                o_cmd.scan    = 1'b1;
                o_cmd.row_clr = (r_k == '0);
                if (r_k == r_n_m1) begin
                    n_state = S_DRAIN1;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_DRAIN1: begin
                n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                n_state = S_NEG;
            end
            S_NEG: begin
                o_cmd.neg = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_k       = '0;
                if (r_i == r_n_m2) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_base  = r_base + AW'(r_n);
                    n_state = S_ROW;
                end
            end
            S_FR: begin
                o_cmd.fr        = 1'b1;
                o_cmd.mat_raddr = r_base + AW'(r_n_m1);
                if (r_i == r_n_m2) begin
                    n_state = S_FR_DRAIN;
                end else begin
                    n_i    = r_i + IW'(1);
                    n_base = r_base + AW'(r_n);
                end
            end
            S_FR_DRAIN: begin
                n_state = S_FR_ONE;
            end
            S_FR_ONE: begin
                o_cmd.vec_wsel  = nvr_pkg::VW_ONE;
                o_cmd.vec_waddr = r_n_m1;
                n_k             = '0;
                n_state         = S_OUT_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_k == r_n_m1);
                n_state        = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_stat.out_acc) begin
                    if (r_k == r_n_m1) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_ERR_WAIT: begin
                if (i_stat.out_acc) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (i_cfg_we) begin
            n_n      = w_nc;
            n_n_m1   = IW'(w_nc - CW'(1));
            n_n_m2   = IW'(w_nc - CW'(2));
            n_tot_m1 = AW'(w_total - (2*CW)'(1));
            n_tot_m2 = AW'(w_total - (2*CW)'(2));
            n_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_n      <= CW'(2);
            r_n_m1   <= IW'(1);
            r_n_m2   <= '0;
            r_tot_m1 <= AW'(1);
            r_tot_m2 <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_base   <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_n      <= n_n;
            r_n_m1   <= n_n_m1;
            r_n_m2   <= n_n_m2;
            r_tot_m1 <= n_tot_m1;
            r_tot_m2 <= n_tot_m2;
            r_k      <= n_k;
            r_i      <= n_i;
            r_base   <= n_base;
        end
    end

endmodule

### hw/rtl/null_vector_from_rref.sv
// ============================================================================
// null_vector_from_rref - null-space vector of an RREF matrix
// Load one entry per cycle; N(N-1) beats. Then a decide step, then either
// the full-rank path (negated last column) or back-substitution (one MAC
// pass per row), then each result beat is read, loaded and held until taken.
// No input beat is taken from the last entry until the last result leaves.
// Synchronous active-low reset: sequencer idle, column count 2, stores kept.
// ============================================================================
module null_vector_from_rref (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nvr_pkg::COL_W-1:0]    i_cfg_wdata,   // column_count
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nvr_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] matrix_entry
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [nvr_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] vector_value
    output logic                         m_axis_tlast,  // vector_last
    output logic [1:0]                   m_axis_tuser   // [0] status, [1] saturated
);

    nvr_pkg::t_cmd  w_cmd;
    nvr_pkg::t_stat w_stat;

    nvr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    nvr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_user  (m_axis_tuser)
    );

endmodule

### tb/null_vector_from_rref_test.sv
// ============================================================================
// null_vector_from_rref_test - self-checking bench for null_vector_from_rref
// Streams RREF matrices of several column counts into the block and compares
// every result beat against an in-bench back-substitution predictor. Covers
// full-rank, rank-deficient, zero-first-entry and noise matrices, saturation,
// random stalls on both sides and one long result back-pressure stretch.
// ============================================================================
module null_vector_from_rref_test;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;
    localparam int TAIL_CYCLES  = 1500;

    localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam longint             ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint             ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        status;
        logic        clipped;
    } t_vector_beat;

    typedef enum {MX_FULL_RANK, MX_DEFICIENT, MX_FIRST_ZERO, MX_NOISE} t_matrix_kind;

    class null_vector_board;
        logic signed [31:0] entries [nvr_pkg::MAT_DEPTH];
        int                 fill;
        int                 columns;
        int                 errors;
        t_vector_beat       vector_q[$];

        function new();
            fill    = 0;
            columns = 2;
            errors  = 0;
        endfunction

        function void set_columns(logic [nvr_pkg::COL_W-1:0] raw);
            if (raw < 2)
                columns = 2;
            else if (raw > nvr_pkg::MAX_COLUMNS)
                columns = nvr_pkg::MAX_COLUMNS;
            else
                columns = int'(raw);
            fill = 0;
        endfunction

        function logic signed [31:0] entry_at(int row, int col);
            return entries[row * columns + col];
        endfunction

        static function longint sat_add(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? ACC_MIN : ACC_MAX;
            return s;
        endfunction

        // -acc in Q32.32 rounded half up to Q16.16, clipped to 32 bits
        static function logic signed [31:0] round_negated(longint acc, output logic clip);
            longint neg;
            longint t;
            neg  = (acc == ACC_MIN) ? ACC_MAX : -acc;
            clip = 1'b1;
            if (neg >= (64'sd1 <<< 47) - 32768)
                return Q_MAX;
            if (neg < -(64'sd1 <<< 47) - 32768)
                return Q_MIN;
            clip = 1'b0;
            t    = neg + 32768;
            return t[47:16];
        endfunction

        function void solve_vector();
            logic signed [31:0] vec [nvr_pkg::MAX_COLUMNS];
            logic               clip [nvr_pkg::MAX_COLUMNS];
            logic signed [31:0] m;
            longint             acc;
            int                 rows;
            int                 lead;
            rows = columns - 1;
            if (entries[0] == 0) begin
                vector_q.push_back('{32'h0, 1'b1, 1'b1, 1'b0});
                return;
            end
            if (entry_at(rows - 1, rows - 1) == nvr_pkg::ONE_Q16) begin
                vec[rows]  = nvr_pkg::ONE_Q16;
                clip[rows] = 1'b0;
                for (int i = 0; i < rows; i++) begin
                    m       = entry_at(i, rows);
                    clip[i] = (m == Q_MIN);
                    vec[i]  = clip[i] ? Q_MAX : -m;
                end
            end else begin
                for (int k = 0; k < columns; k++) begin
                    vec[k]  = (k % 2) ? nvr_pkg::ONE_Q16 : nvr_pkg::NEG_ONE_Q16;
                    clip[k] = 1'b0;
                end
                for (int i = 0; i < rows; i++) begin
                    lead = columns;
                    for (int k = columns - 1; k >= 0; k--)
                        if (entry_at(i, k) == nvr_pkg::ONE_Q16)
                            lead = k;
                    if (lead < columns) begin
                        acc = 0;
                        for (int k = lead + 1; k < columns; k++)
                            acc = sat_add(acc, longint'(vec[k]) * longint'(entry_at(i, k)));
                        vec[lead] = round_negated(acc, clip[lead]);
                    end
                end
            end
            for (int k = 0; k < columns; k++)
                vector_q.push_back('{vec[k], (k == rows), 1'b0, clip[k]});
        endfunction

        function void note_entry(logic [31:0] entry);
            entries[fill] = entry;
            fill++;
            if (fill == columns * (columns - 1)) begin
                fill = 0;
                solve_vector();
            end
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_beat(logic [31:0] value, logic last, logic [1:0] user);
            t_vector_beat want;
            if (vector_q.size() == 0) begin
                report($sformatf("unexpected beat %h last %b user %b", value, last, user));
                return;
            end
            want = vector_q.pop_front();
            if (value !== want.value || last !== want.last ||
                user[0] !== want.status || user[1] !== want.clipped)
                report($sformatf({"got %h last %b status %b sat %b, ",
                                  "want %h last %b status %b sat %b"},
                                 value, last, user[0], user[1],
                                 want.value, want.last, want.status, want.clipped));
        endtask

        task finish_check();
            if (vector_q.size() != 0)
                report($sformatf("%0d expected beats never arrived", vector_q.size()));
        endtask
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [nvr_pkg::COL_W-1:0]     i_cfg_wdata   = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [nvr_pkg::DATA_W-1:0]    s_axis_tdata  = '0;   // [31:0] matrix_entry
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [nvr_pkg::DATA_W-1:0]    m_axis_tdata;         // [31:0] vector_value
    logic                          m_axis_tlast;         // vector_last
    logic [1:0]                    m_axis_tuser;         // [0] status, [1] saturated

    null_vector_board board = new();
    logic [31:0]      mat_buf [nvr_pkg::MAT_DEPTH];
    bit               src_idle_on  = 1'b1;
    bit               sink_idle_on = 1'b1;
    int               hold_request = 0;
    int               items_sent   = 0;
    int               cycle_count  = 0;

    null_vector_from_rref dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[null_vector_from_rref] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(sink_idle_on && $urandom_range(0, 99) < 18);
            end
        end
    end

    function automatic logic [31:0] pick_entry();
        case ($urandom_range(0, 11))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2, 3:    return $urandom();
            4:       return nvr_pkg::ONE_Q16;
            5:       return nvr_pkg::NEG_ONE_Q16;
            6:       return 32'h0;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic void build_matrix(t_matrix_kind kind, int n);
        logic pivot_col [nvr_pkg::MAX_COLUMNS];
        int   lead_of [nvr_pkg::MAX_COLUMNS];
        int   rows;
        int   col;
        rows = n - 1;
        col  = 0;
        for (int idx = 0; idx < n * rows; idx++)
            mat_buf[idx] = (kind == MX_NOISE || kind == MX_FIRST_ZERO) ? pick_entry() : 32'h0;
        for (int k = 0; k < n; k++)
            pivot_col[k] = 1'b0;
        case (kind)
            MX_FULL_RANK: begin
                for (int i = 0; i < rows; i++) begin
                    mat_buf[i * n + i]    = nvr_pkg::ONE_Q16;
                    mat_buf[i * n + rows] = pick_entry();
                end
            end
            MX_FIRST_ZERO: begin
                mat_buf[0] = 32'h0;
            end
            MX_DEFICIENT: begin
                for (int i = 0; i < rows; i++) begin
                    if (i > 0)
                        col += $urandom_range(0, 1);
                    lead_of[i] = n;
                    if (col < n && $urandom_range(0, 5) != 0) begin
                        lead_of[i]         = col;
                        pivot_col[col]     = 1'b1;
                        mat_buf[i * n + col] = nvr_pkg::ONE_Q16;
                        col++;
                    end
                end
                for (int i = 0; i < rows; i++)
                    if (lead_of[i] < n)
                        for (int k = lead_of[i] + 1; k < n; k++)
                            if (!pivot_col[k])
                                mat_buf[i * n + k] = pick_entry();
                // column zero sometimes loses its pivot
                if ($urandom_range(0, 3) == 0)
                    mat_buf[0] = pick_entry() | 32'h2;
            end
            default: ;
        endcase
    endfunction

    task automatic send_entry(logic [31:0] value);
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < 18) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_entry(value);
        items_sent++;
    endtask

    task automatic send_matrix(t_matrix_kind kind);
        int n;
        n = board.columns;
        build_matrix(kind, n);
        for (int idx = 0; idx < n * (n - 1); idx++)
            send_entry(mat_buf[idx]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.vector_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_columns(logic [nvr_pkg::COL_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_columns(value);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_matrix_kind pick_kind();
        case ($urandom_range(0, 19))
            0, 1:          return MX_FIRST_ZERO;
            2, 3, 4:       return MX_NOISE;
            5, 6, 7, 8, 9: return MX_FULL_RANK;
            default:       return MX_DEFICIENT;
        endcase
    endfunction

    initial begin : stimulus
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two columns at reset: clipped negation, zero first entry,
        // row without pivot, pivot away from column zero
        send_entry(nvr_pkg::ONE_Q16);
        send_entry(Q_MIN);
        send_entry(32'h0);
        send_entry(32'h0003_0000);
        send_entry(32'h0002_0000);
        send_entry(32'h0003_0000);
        send_entry(Q_MAX);
        send_entry(nvr_pkg::ONE_Q16);

        // three columns: negated dot product clips high, second row empty
        write_columns(6'd3);
        send_entry(nvr_pkg::ONE_Q16);
        send_entry(Q_MIN);
        send_entry(Q_MAX);
        send_entry(32'h0);
        send_entry(32'h0);
        send_entry(32'h0);

        // partial load dropped by the next register write
        send_entry(nvr_pkg::ONE_Q16);
        send_entry(32'hffff_ffff);
        send_entry(32'h0001_8000);
        write_columns(6'd0);
        repeat (3) send_matrix(pick_kind());

        // column count clamps high; the partial load is dropped
        write_columns(6'd63);
        repeat (5) send_entry(pick_entry());
        write_columns(6'd1);
        repeat (3) send_matrix(pick_kind());

        // long result stall while input keeps coming
        write_columns(6'd3);
        hold_request = HOLD_CYCLES;
        repeat (4) send_matrix(MX_DEFICIENT);

        // stretch without any idle cycles
        wait_idle();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_columns(6'd4);
        repeat (8) send_matrix(pick_kind());
        wait_idle();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0:       write_columns(6'($urandom_range(0, 1)));
                1:       write_columns(6'($urandom_range(7, 12)));
                default: write_columns(6'($urandom_range(2, 6)));
            endcase
            repeat ($urandom_range(2, 5))
                if (items_sent < target)
                    send_matrix(pick_kind());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.finish_check();
        if (board.errors == 0)
            $display("[null_vector_from_rref] OK");
        else
            $display("[null_vector_from_rref] ERROR");
        $finish;
    end

endmodule
